// ----- rtl/ypb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the RGB to YPbPr converter.
// No dependencies; every other file imports this package.

package ypb_pkg;

   // Fraction bits of the results: 1.0 is 2**FRAC_BITS.
   localparam int FRAC_BITS = 16;

   // Fixed widths set by the interface fields.
   localparam int CH_W   = 16;
   localparam int COEF_W = 21;              // signed matrix coefficients, units of 1e-6
   localparam int LANES  = 3;

   // Lane (matrix row) indexes.
   localparam int LANE_LUMA = 0;
   localparam int LANE_BLUE = 1;
   localparam int LANE_RED  = 2;

   // Datapath widths.
   localparam int PROD_W = COEF_W + CH_W;             // one coefficient times one channel
   localparam int ACC_W  = PROD_W + 1;                // signed row sum
   localparam int MAG_W  = PROD_W;                    // row sum magnitude
   localparam int DEN_W  = CH_W + COEF_W;             // max_value * 1e6
   localparam int DD_W   = DEN_W + 1;                 // divisor 2 * den
   localparam int Q_W    = FRAC_BITS + 2;             // quotient bits before saturation
   localparam int NUM_W  = MAG_W + Q_W;               // (mag << (FRAC_BITS+1)) + den
   localparam int OUT_W  = FRAC_BITS + 1;

   // Pipeline depth: matrix stages, then setup, one stage per quotient bit, output.
   localparam int MAT_STAGES = 3;
   localparam int DIV_STAGES = Q_W + 2;
   localparam int PIPE_DEPTH = MAT_STAGES + DIV_STAGES;
   localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

   localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1000000);
   localparam logic [CH_W-1:0]   MAX_RESET = CH_W'(255);

   // Clamp limits of the quotient magnitude.
   localparam logic [Q_W-1:0] LIM_ONE  = Q_W'(1) << FRAC_BITS;
   localparam logic [Q_W-1:0] LIM_HALF = Q_W'(1) << (FRAC_BITS - 1);

   // BT.601 matrix, row = output lane, column = red, green, blue.
   localparam logic signed [COEF_W-1:0] COEF [LANES][LANES] = '{
      '{ 21'sd299000,  21'sd587000,  21'sd114000},
      '{-21'sd168736, -21'sd331264,  21'sd500000},
      '{ 21'sd500000, -21'sd418688, -21'sd81312 }
   };

   // Rounding numerator of one lane, with the sign of the row sum.
   typedef struct packed {
      logic             neg;
      logic [NUM_W-1:0] num;
   } lane_num_type;

   // Restoring division state of one lane.
   typedef struct packed {
      logic            neg;
      logic            sat;
      logic [DD_W-1:0] rem;
      logic [Q_W-1:0]  nq;   // numerator bits shift out, quotient bits shift in
   } div_lane_type;

endpackage

// ----- rtl/ypb_matrix.sv -----
`timescale 1ns / 1ps
// Matrix part of the converter: products, row sums and rounding numerators.
// Depends on ypb_pkg.

module ypb_matrix (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [ypb_pkg::CH_W-1:0]               red,
   input  logic [ypb_pkg::CH_W-1:0]               green,
   input  logic [ypb_pkg::CH_W-1:0]               blue,
   input  logic [ypb_pkg::DEN_W-1:0]              den,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output ypb_pkg::lane_num_type [ypb_pkg::LANES-1:0] out_lanes
);
   import ypb_pkg::*;

   logic [CH_W-1:0]          ch [LANES];
   logic signed [PROD_W-1:0] prod_in [LANES][LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES][LANES];
   logic signed [ACC_W-1:0]  acc_in [LANES];
   logic signed [ACC_W-1:0]  acc_ff [LANES];
   lane_num_type [LANES-1:0] num_in;
   lane_num_type [LANES-1:0] num_ff;
   logic [MAT_STAGES-1:0]    v_ff;
   logic [MAT_STAGES:0]      rdy;

   function automatic logic signed [PROD_W-1:0] coef_mul(
      input logic signed [COEF_W-1:0] c,
      input logic [CH_W-1:0]          x
   );
      logic signed [COEF_W+CH_W:0] full;
      full = c * $signed({1'b0, x});
      return full[PROD_W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sext(input logic signed [PROD_W-1:0] p);
      return {p[PROD_W-1], p};
   endfunction

   function automatic lane_num_type make_num(
      input logic signed [ACC_W-1:0] acc,
      input logic [DEN_W-1:0]        d
   );
      lane_num_type     r;
      logic [ACC_W-1:0] absv;
      logic [MAG_W-1:0] mag;
      r.neg = acc[ACC_W-1];
      absv  = r.neg ? -acc : acc;
      mag   = absv[MAG_W-1:0];
      r.num = {mag, {(Q_W){1'b0}}} >> 1;
      r.num = r.num + NUM_W'(d);
      return r;
   endfunction

   assign ch[0] = red;
   assign ch[1] = green;
   assign ch[2] = blue;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < LANES; j++) begin
            prod_in[i][j] = coef_mul(COEF[i][j], ch[j]);
         end
         acc_in[i] = sext(prod_ff[i][0]) + sext(prod_ff[i][1]) + sext(prod_ff[i][2]);
         num_in[i] = make_num(acc_ff[i], den);
      end
   end

   // Stage s loads when it is empty or its content moves on.
   always_comb begin
      rdy[MAT_STAGES] = out_ready;
      for (int s = MAT_STAGES - 1; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[MAT_STAGES-1];
   assign out_lanes = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) prod_ff <= prod_in;
      if (rdy[1] && v_ff[0])  acc_ff  <= acc_in;
      if (rdy[2] && v_ff[1])  num_ff  <= num_in;
   end

endmodule

// ----- rtl/ypb_divider.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider for the three lanes, one quotient bit per stage,
// followed by clamping and the output register. Depends on ypb_pkg.

module ypb_divider (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  ypb_pkg::lane_num_type [ypb_pkg::LANES-1:0] in_lanes,
   input  logic [ypb_pkg::DEN_W-1:0]              den,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ypb_pkg::OUT_W-1:0]              rsp_luma,
   output logic signed [ypb_pkg::OUT_W-1:0]       rsp_blue_diff,
   output logic signed [ypb_pkg::OUT_W-1:0]       rsp_red_diff
);
   import ypb_pkg::*;

   localparam int STEPS = Q_W;

   logic [DD_W-1:0]          dvs;
   logic [STEPS:0]           v_ff;
   div_lane_type [LANES-1:0] lane_in [STEPS+1];
   div_lane_type [LANES-1:0] lane_ff [STEPS+1];
   logic [STEPS+1:0]         rdy;
   logic                     rsp_valid_ff;
   logic [OUT_W-1:0]         luma_ff;
   logic [OUT_W-1:0]         blue_diff_ff;
   logic [OUT_W-1:0]         red_diff_ff;
   logic [OUT_W-1:0]         luma_in;
   logic [OUT_W-1:0]         blue_diff_in;
   logic [OUT_W-1:0]         red_diff_in;

   // Saturate up front when the quotient reaches 2**Q_W, else seed the remainder.
   function automatic div_lane_type div_start(
      input lane_num_type    x,
      input logic [DD_W-1:0] d
   );
      div_lane_type     r;
      logic [MAG_W-1:0] hi;
      hi    = x.num[NUM_W-1:Q_W];
      r.neg = x.neg;
      r.sat = DD_W'(hi) >= d;
      r.rem = r.sat ? '0 : DD_W'(hi);
      r.nq  = x.num[Q_W-1:0];
      return r;
   endfunction

   function automatic div_lane_type div_step(
      input div_lane_type    x,
      input logic [DD_W-1:0] d
   );
      div_lane_type  r;
      logic [DD_W:0] rext;
      logic [DD_W:0] diff;
      logic          ge;
      rext  = {x.rem, x.nq[Q_W-1]};
      diff  = rext - {1'b0, d};
      ge    = rext >= {1'b0, d};
      r.neg = x.neg;
      r.sat = x.sat;
      r.rem = ge ? diff[DD_W-1:0] : rext[DD_W-1:0];
      r.nq  = {x.nq[Q_W-2:0], ge};
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] clamp_mag(
      input div_lane_type   x,
      input logic [Q_W-1:0] lim
   );
      logic [Q_W-1:0] m;
      m = (x.sat || x.nq > lim) ? lim : x.nq;
      return m[OUT_W-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] signed_clamp(input div_lane_type x);
      logic [OUT_W-1:0] m;
      m = clamp_mag(x, LIM_HALF);
      return x.neg ? -m : m;
   endfunction

   assign dvs = {den, 1'b0};

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_in[0][l] = div_start(in_lanes[l], dvs);
         for (int s = 1; s <= STEPS; s++) begin
            lane_in[s][l] = div_step(lane_ff[s-1][l], dvs);
         end
      end
   end

   // Negative luma clamps to zero.
   assign luma_in      = lane_ff[STEPS][LANE_LUMA].neg ? '0
                         : clamp_mag(lane_ff[STEPS][LANE_LUMA], LIM_ONE);
   assign blue_diff_in = signed_clamp(lane_ff[STEPS][LANE_BLUE]);
   assign red_diff_in  = signed_clamp(lane_ff[STEPS][LANE_RED]);

   always_comb begin
      rdy[STEPS+1] = !rsp_valid_ff || rsp_ready;
      for (int s = STEPS; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS; s++) begin
            if (rdy[s]) v_ff[s] <= v_ff[s-1];
         end
         if (rdy[STEPS+1]) rsp_valid_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) lane_ff[0] <= lane_in[0];
      for (int s = 1; s <= STEPS; s++) begin
         if (rdy[s] && v_ff[s-1]) lane_ff[s] <= lane_in[s];
      end
      if (rdy[STEPS+1] && v_ff[STEPS]) begin
         luma_ff      <= luma_in;
         blue_diff_ff <= blue_diff_in;
         red_diff_ff  <= red_diff_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_luma      = luma_ff;
   assign rsp_blue_diff = $signed(blue_diff_ff);
   assign rsp_red_diff  = $signed(red_diff_ff);

endmodule

// ----- rtl/rgb_to_ypbpr_unit.sv -----
`timescale 1ns / 1ps
// Top level of the BT.601 RGB to YPbPr converter: max_value register,
// matrix pipeline and divider pipeline. Depends on ypb_pkg, ypb_matrix, ypb_divider.
//
// Converts RGB words into Y, Pb, Pr with FRAC_BITS fraction bits
// (1.0 = 65536 at the default). Each channel is taken as a fraction of max_value
// (0 counts as 1), the BT.601 matrix is applied with coefficients held in
// millionths, the exact quotient is rounded to nearest with ties away from
// zero, and Y is clamped to 0..1, Pb and Pr to -0.5..0.5. The pipeline accepts
// one word every cycle while rsp_ready lets results drain, and holds up to
// FRAC_BITS+7 words (23 at the default). The restoring divider resolves one
// quotient bit per stage over FRAC_BITS+2 stages, behind three matrix stages
// (multiply, sum, rounding numerator) and one saturation check stage, and
// ahead of the output register. Every stage has its own valid bit and loads
// whenever it is empty or drains, so bubbles close up while a result waits on
// rsp_ready. Write max_value only while the pipeline is empty; the divisor
// register follows the write in the same edge.

module rgb_to_ypbpr_unit (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [ypb_pkg::CH_W-1:0]          csr_max_value,
   // pixel words in
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ypb_pkg::CH_W-1:0]          req_red,
   input  logic [ypb_pkg::CH_W-1:0]          req_green,
   input  logic [ypb_pkg::CH_W-1:0]          req_blue,
   // converted words out
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ypb_pkg::OUT_W-1:0]         rsp_luma,
   output logic signed [ypb_pkg::OUT_W-1:0]  rsp_blue_diff,
   output logic signed [ypb_pkg::OUT_W-1:0]  rsp_red_diff
);
   import ypb_pkg::*;

   localparam logic [DEN_W-1:0] DEN_RESET = DEN_W'(MAX_RESET) * DEN_W'(COEF_ONE);

   logic [CH_W-1:0]          max_eff;
   logic [DEN_W-1:0]         den_in;
   logic [DEN_W-1:0]         den_ff;
   logic                     mat_valid;
   logic                     div_ready;
   lane_num_type [LANES-1:0] mat_lanes;
   logic [OCC_W-1:0]         occ_in;
   logic [OCC_W-1:0]         occ_ff;

   // Hold the divisor max_value * 1e6 rather than max_value itself;
   // treat a zero maximum as one.
   assign max_eff = (csr_max_value == '0) ? CH_W'(1) : csr_max_value;
   assign den_in  = DEN_W'(max_eff) * DEN_W'(COEF_ONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         den_ff <= DEN_RESET;
      end else if (csr_wr_en) begin
         den_ff <= den_in;
      end
   end

   // Multiply, sum rows, build rounding numerators.
   ypb_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .den       (den_ff),
      .out_valid (mat_valid),
      .out_ready (div_ready),
      .out_lanes (mat_lanes)
   );

   // Divide, clamp, register the result.
   ypb_divider u_divider (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mat_valid),
      .in_ready      (div_ready),
      .in_lanes      (mat_lanes),
      .den           (den_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_luma      (rsp_luma),
      .rsp_blue_diff (rsp_blue_diff),
      .rsp_red_diff  (rsp_red_diff)
   );

   // Words in flight, for the checks below.
   assign occ_in = occ_ff + OCC_W'(req_valid && req_ready) - OCC_W'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // The pipeline never holds more words than it has stages.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(PIPE_DEPTH))
      else $error("pipeline occupancy above depth");

   // An empty pipeline always takes a word.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      occ_ff == '0 |-> req_ready)
      else $error("empty pipeline refuses input");

   // A result is only shown for a word that was taken.
   a_valid_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != '0)
      else $error("result without a word in flight");

   // Delivered results respect the clamps.
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_luma <= OUT_W'(LIM_ONE))
                    && ($signed(rsp_blue_diff) >= -$signed({1'b0, LIM_HALF}))
                    && ($signed(rsp_blue_diff) <= $signed({1'b0, LIM_HALF}))
                    && ($signed(rsp_red_diff) >= -$signed({1'b0, LIM_HALF}))
                    && ($signed(rsp_red_diff) <= $signed({1'b0, LIM_HALF})))
      else $error("result outside clamp range");

endmodule
